// ===== hw/rtl/forward_nearest_waypoint_search_macros.svh =====
// ----------------------------------------------------------------------------
// Forward nearest waypoint search assertion macros
// Shared assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef FORWARD_NEAREST_WAYPOINT_SEARCH_MACROS_SVH
`define FORWARD_NEAREST_WAYPOINT_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FNWS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("forward nearest waypoint search: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FNWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("forward nearest waypoint search: next-cycle check failed");

`endif

// ===== hw/rtl/fnws_pkg.sv =====
// ----------------------------------------------------------------------------
// Forward nearest waypoint search package
// Shared constants, command and status codes, and interface structs.
// ----------------------------------------------------------------------------
package fnws_pkg;

  localparam int MAX_WAYPOINTS_DEF = 1024;
  localparam int COORD_W           = 32;
  localparam int RADIUS_W          = 24;
  localparam int SQ_W              = 2 * RADIUS_W;
  localparam int CMD_W             = 2;
  localparam int RESULT_W          = 11;
  localparam int STATUS_W          = 2;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd1000000;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef struct packed {
    logic                valid;
    logic [RESULT_W-1:0] index;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

// ===== hw/rtl/fnws_wpt_mem.sv =====
// ----------------------------------------------------------------------------
// Waypoint table memory
// One write port and one registered read port holding east and north pairs.
// ----------------------------------------------------------------------------
module fnws_wpt_mem #(
  parameter int DEPTH = fnws_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                            clk,
  input  fnws_pkg::mem_ctl_t              ctl,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [2*fnws_pkg::COORD_W-1:0]  wdata,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output logic [2*fnws_pkg::COORD_W-1:0]  rdata
);

  logic [2*fnws_pkg::COORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/fnws_square.sv =====
// ----------------------------------------------------------------------------
// Shared squaring unit
// Registered 24 by 24 bit square, reused for the radius and both offsets.
// ----------------------------------------------------------------------------
module fnws_square (
  input  logic                          clk,
  input  logic [fnws_pkg::RADIUS_W-1:0] a,
  output logic [fnws_pkg::SQ_W-1:0]     p
);

  always_ff @(posedge clk) begin
    p <= fnws_pkg::SQ_W'(a) * fnws_pkg::SQ_W'(a);
  end

endmodule

// ===== hw/rtl/fnws_seq.sv =====
// ----------------------------------------------------------------------------
// Waypoint search sequencer
// Table bookkeeping and the per-waypoint scan that drives the shared squarer.
// ----------------------------------------------------------------------------
module fnws_seq #(
  parameter int MAX_WAYPOINTS = fnws_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic [fnws_pkg::CMD_W-1:0]            cmd,
  input  logic [fnws_pkg::COORD_W-1:0]          pos_x,
  input  logic [fnws_pkg::COORD_W-1:0]          pos_y,
  input  logic [fnws_pkg::RADIUS_W-1:0]         radius,
  input  logic                                  out_free,
  output logic                                  ready,
  output fnws_pkg::res_t                        res,
  output fnws_pkg::mem_ctl_t                    mem_ctl,
  output logic [$clog2(MAX_WAYPOINTS)-1:0]      waddr,
  output logic [2*fnws_pkg::COORD_W-1:0]        wdata,
  output logic [$clog2(MAX_WAYPOINTS)-1:0]      raddr,
  input  logic [2*fnws_pkg::COORD_W-1:0]        rdata,
  output logic [fnws_pkg::RADIUS_W-1:0]         sq_a,
  input  logic [fnws_pkg::SQ_W-1:0]             sq_p
);

  localparam int IW = $clog2(MAX_WAYPOINTS);
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);
  localparam int RW = fnws_pkg::RESULT_W;
  localparam int XW = fnws_pkg::COORD_W;
  localparam int RSW = fnws_pkg::RADIUS_W;
  localparam int SW = fnws_pkg::SQ_W;
  localparam int DW = XW + 1;

  typedef enum logic [8:0] {
    IDLE  = 9'b000000001,
    QINIT = 9'b000000010,
    QRAD  = 9'b000000100,
    RD    = 9'b000001000,
    DIFF  = 9'b000010000,
    SQX   = 9'b000100000,
    SQY   = 9'b001000000,
    CMP   = 9'b010000000,
    FIN   = 9'b100000000
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [IW-1:0] cur;
  logic [IW-1:0] idx;
  logic [IW-1:0] pick;
  logic found;
  logic [SW:0] best;
  logic [XW-1:0] px;
  logic [XW-1:0] py;
  logic [RSW-1:0] dx;
  logic [RSW-1:0] dy;
  logic [SW-1:0] sqx;
  logic [RW-1:0] res_index;
  logic [fnws_pkg::STATUS_W-1:0] res_status;

  logic signed [DW-1:0] diff_x;
  logic signed [DW-1:0] diff_y;
  logic [DW-1:0] adx;
  logic [DW-1:0] ady;
  logic out_range;
  logic [SW:0] sum_sq;
  logic hit;
  logic found_now;
  logic [IW-1:0] pick_now;
  logic has_next;
  logic can_start;
  logic room;

  assign diff_x = $signed({rdata[XW-1], rdata[XW-1:0]}) - $signed({px[XW-1], px});
  assign diff_y = $signed({rdata[2*XW-1], rdata[2*XW-1:XW]}) - $signed({py[XW-1], py});
  assign adx = diff_x[DW-1] ? (~diff_x + DW'(1)) : diff_x;
  assign ady = diff_y[DW-1] ? (~diff_y + DW'(1)) : diff_y;
  assign out_range = (adx > DW'(radius)) || (ady > DW'(radius));

  assign sum_sq = {1'b0, sqx} + {1'b0, sq_p};
  assign hit = (state == CMP) && (sum_sq <= best);
  assign found_now = found || hit;
  assign pick_now = hit ? idx : pick;
  assign has_next = ((CW+1)'(idx) + (CW+1)'(2)) < (CW+1)'(count);
  assign can_start = (CW'(cur) + CW'(1)) < count;
  assign room = count < CW'(MAX_WAYPOINTS);

  assign ready = (state == IDLE);

  assign mem_ctl.we = (state == IDLE) && accept && (cmd == fnws_pkg::CMD_APPEND) && room;
  assign mem_ctl.re = (state == RD);
  assign waddr = count[IW-1:0];
  assign wdata = {pos_y, pos_x};
  assign raddr = idx;

  assign res.valid  = (state == FIN) && out_free;
  assign res.index  = res_index;
  assign res.status = res_status;

  always_comb begin
    case (state)
      QINIT:   sq_a = radius;
      SQX:     sq_a = dx;
      SQY:     sq_a = dy;
      default: sq_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      cur   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            case (cmd)
              fnws_pkg::CMD_QUERY: begin
                state <= QINIT;
              end
              fnws_pkg::CMD_CLEAR: begin
                count <= '0;
                cur   <= '0;
                state <= FIN;
              end
              fnws_pkg::CMD_APPEND: begin
                if (room) begin
                  count <= count + CW'(1);
                end
                state <= FIN;
              end
              default: begin
                state <= FIN;
              end
            endcase
          end
        end
        QINIT: begin
          state <= can_start ? QRAD : FIN;
        end
        QRAD: begin
          state <= RD;
        end
        RD: begin
          state <= DIFF;
        end
        DIFF: begin
          if (!out_range) begin
            state <= SQX;
          end else if (has_next) begin
            state <= RD;
          end else begin
            if (found_now) begin
              cur <= pick_now;
            end
            state <= FIN;
          end
        end
        SQX: begin
          state <= SQY;
        end
        SQY: begin
          state <= CMP;
        end
        CMP: begin
          if (has_next) begin
            state <= RD;
          end else begin
            if (found_now) begin
              cur <= pick_now;
            end
            state <= FIN;
          end
        end
        FIN: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      IDLE: begin
        px <= pos_x;
        py <= pos_y;
        if ((cmd == fnws_pkg::CMD_APPEND) && !room) begin
          res_status <= fnws_pkg::STATUS_FULL;
        end else begin
          res_status <= fnws_pkg::STATUS_OK;
        end
        if (cmd == fnws_pkg::CMD_CLEAR) begin
          res_index <= '0;
        end else if ((cmd == fnws_pkg::CMD_APPEND) && room) begin
          res_index <= RW'(count + CW'(1));
        end else begin
          res_index <= RW'(count);
        end
      end
      QINIT: begin
        idx <= cur;
        pick <= cur;
        found <= 1'b0;
        res_index <= RW'(cur);
        res_status <= fnws_pkg::STATUS_NONE;
      end
      QRAD: begin
        best <= {1'b0, sq_p};
      end
      DIFF: begin
        dx <= adx[RSW-1:0];
        dy <= ady[RSW-1:0];
        if (out_range) begin
          if (has_next) begin
            idx <= idx + IW'(1);
          end else begin
            res_index <= found_now ? RW'(pick_now) : RW'(cur);
            res_status <= found_now ? fnws_pkg::STATUS_OK : fnws_pkg::STATUS_NONE;
          end
        end
      end
      SQY: begin
        sqx <= sq_p;
      end
      CMP: begin
        if (hit) begin
          best <= sum_sq;
          pick <= idx;
          found <= 1'b1;
        end
        if (has_next) begin
          idx <= idx + IW'(1);
        end else begin
          res_index <= found_now ? RW'(pick_now) : RW'(cur);
          res_status <= found_now ? fnws_pkg::STATUS_OK : fnws_pkg::STATUS_NONE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/forward_nearest_waypoint_search.sv =====
// ----------------------------------------------------------------------------
// Forward nearest waypoint search
// Waypoint table with a forward scan for the nearest point within a radius.
// ----------------------------------------------------------------------------
// The slave stream carries commands: tuser selects clear, append or query,
// and tdata carries the east and north coordinates. Each transfer yields one
// result transfer on the master stream: the stored waypoint count for clear
// and append, or the current waypoint index after a query, with a status in
// tuser. The user must write the search radius through the cfg channel
// only while idle; the block itself does not enforce it. Clear, append
// and the unused command go from IDLE straight to FIN, which loads the
// output register. A query first squares the radius in QINIT and QRAD,
// then visits each waypoint from the current index to the next-to-last
// one through the single read port of the table and the one shared
// squaring unit: RD and DIFF for a point outside the radius box, plus SQX,
// SQY and CMP for one inside, then FIN; one command is processed at a time.
// Reset empties the table, zeroes the current index and restores the
// default radius. When the receiver stalls, the result waits in the output
// register; the next command can still be accepted and processed, and its
// result is held back until the waiting transfer completes.
module forward_nearest_waypoint_search #(
  parameter int MAX_WAYPOINTS = fnws_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [2*fnws_pkg::COORD_W-1:0]      s_tdata,  // pos_x, pos_y
  input  logic [fnws_pkg::CMD_W-1:0]          s_tuser,  // cmd
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [15:0]                         m_tdata,  // result_index, zero fill
  output logic [fnws_pkg::STATUS_W-1:0]       m_tuser,  // status
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fnws_pkg::RADIUS_W-1:0]       cfg_data  // search_radius
);

  `include "forward_nearest_waypoint_search_macros.svh"

  localparam int AW = $clog2(MAX_WAYPOINTS);

  logic [fnws_pkg::RADIUS_W-1:0] radius;
  logic accept;
  logic out_free;
  fnws_pkg::res_t res;
  fnws_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [2*fnws_pkg::COORD_W-1:0] wdata;
  logic [2*fnws_pkg::COORD_W-1:0] rdata;
  logic [fnws_pkg::RADIUS_W-1:0] sq_a;
  logic [fnws_pkg::SQ_W-1:0] sq_p;

  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= fnws_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= 16'(res.index);
      m_tuser <= res.status;
    end
  end

  fnws_seq #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (s_tuser),
    .pos_x    (s_tdata[fnws_pkg::COORD_W-1:0]),
    .pos_y    (s_tdata[2*fnws_pkg::COORD_W-1:fnws_pkg::COORD_W]),
    .radius   (radius),
    .out_free (out_free),
    .ready    (s_tready),
    .res      (res),
    .mem_ctl  (mem_ctl),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata),
    .sq_a     (sq_a),
    .sq_p     (sq_p)
  );

  fnws_wpt_mem #(
    .DEPTH(MAX_WAYPOINTS)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  fnws_square u_square (
    .clk (clk),
    .a   (sq_a),
    .p   (sq_p)
  );

  `FNWS_ASSERT_SAME(a_load_when_free, res.valid, !m_tvalid || m_tready)
  `FNWS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `FNWS_ASSERT_SAME(a_no_read_write_overlap, mem_ctl.we, !mem_ctl.re && s_tready)

endmodule
